// ===== sv/huffman_code_bit_packer_assert.svh =====
// Assertion macros shared by the Huffman code bit packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HCBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcbp check failed");

// Next-cycle implication, checked outside reset.
`define HCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcbp check failed");

`endif

// ===== sv/hcbp_pkg.sv =====
// Types and constants for the Huffman code bit packer.
package hcbp_pkg;

    // Item kinds on the input channel; the fourth code is ignored.
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ENCODE = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;

    localparam int BYTE_W = 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  symbol;
        logic [31:0] code_bits;
        logic [5:0]  code_len;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_end;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_STEP  = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_state;

endpackage

// ===== sv/huffman_code_bit_packer.sv =====
// Huffman encoder back end: code table and MSB-first byte packer.
// A load never stalls the input; a flush with bits held stalls it until the output register is
// free. An encode reads the table on accept, aligns the entry, then takes one packing step per
// piece of code that fills a byte or ends the code (at most five for 32 bits). Its input stalls
// until the last step. Each step waits for a free output register, where its byte then waits.
// Reset clears the sequencer, accumulator and output valid; the table is not cleared.
module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  hcbp_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output hcbp_pkg::t_out_item  o_out_data
);

`include "huffman_code_bit_packer_assert.svh"

    // Stored code width is capped at the 32 bits of the input field.
    localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam int LEN_W  = $clog2(CODE_W + 1);
    // The shift register must hold at least one full byte window.
    localparam int SH_W   = (CODE_W > hcbp_pkg::BYTE_W) ? CODE_W : hcbp_pkg::BYTE_W;
    localparam int SH_LW  = $clog2(SH_W + 1);
    localparam int CNT_W  = (LEN_W > 4) ? LEN_W : 4;
    localparam int ADDR_W = (SYMBOL_COUNT > 2) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ENT_W  = CODE_W + LEN_W;

    // Code table: one write port for loads, one registered read port for encodes.
    logic [ENT_W-1:0] mem [SYMBOL_COUNT];
    logic [ENT_W-1:0] r_rd;

    hcbp_pkg::t_state    r_state, n_state;
    logic [7:0]          r_acc, n_acc;
    logic [2:0]          r_held, n_held;
    logic [SH_W-1:0]     r_code, n_code;
    logic [LEN_W-1:0]    r_rem, n_rem;
    logic                r_out_valid, n_out_valid;
    hcbp_pkg::t_out_item r_out, n_out;

    logic               w_accept;
    logic               w_in_range;
    logic [ADDR_W-1:0]  w_addr;
    logic [LEN_W-1:0]   w_len_sat;
    logic [31:0]        w_code_mask;
    logic               w_out_free;
    logic               w_emit;
    logic               w_flush_xfer;

    // Alignment of a freshly read entry.
    logic [CODE_W-1:0]  w_rd_code;
    logic [LEN_W-1:0]   w_rd_len;
    logic [SH_LW-1:0]   w_align_sh;

    // Packing step datapath.
    logic [3:0]         w_avail;
    logic [CNT_W-1:0]   w_rem_ext;
    logic [3:0]         w_take;
    logic [15:0]        w_cat;
    logic [3:0]         w_held_sum;
    logic [LEN_W-1:0]   w_rem_next;

    assign o_in_stall  = (r_state != hcbp_pkg::ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_in_range  = ({1'b0, i_in_data.symbol} < 9'(SYMBOL_COUNT));
    assign w_addr      = i_in_data.symbol[ADDR_W-1:0];
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Loaded lengths saturate at the table width; stray high code bits are dropped.
    assign w_len_sat   = (i_in_data.code_len > 6'(CODE_W)) ? LEN_W'(CODE_W)
                                                           : LEN_W'(i_in_data.code_len);
    assign w_code_mask = ~({32{1'b1}} << w_len_sat);

    always_ff @(posedge i_clk) begin
        if (w_accept && w_in_range && i_in_data.kind == hcbp_pkg::KIND_LOAD) begin
            mem[w_addr] <= {CODE_W'(i_in_data.code_bits & w_code_mask), w_len_sat};
        end
        if (w_accept && i_in_data.kind == hcbp_pkg::KIND_ENCODE) begin
            r_rd <= mem[w_addr];
        end
    end

    assign w_rd_code  = r_rd[ENT_W-1:LEN_W];
    assign w_rd_len   = r_rd[LEN_W-1:0];
    assign w_align_sh = SH_LW'(SH_W) - SH_LW'(w_rd_len);

    // One step moves as many bits as fit in the byte, or all that remain.
    assign w_avail    = 4'd8 - {1'b0, r_held};
    assign w_rem_ext  = CNT_W'(r_rem);
    assign w_take     = (w_rem_ext < CNT_W'(w_avail)) ? w_rem_ext[3:0] : w_avail;
    assign w_cat      = {r_acc, r_code[SH_W-1 -: 8]} << w_take;
    assign w_held_sum = {1'b0, r_held} + w_take;
    assign w_rem_next = r_rem - LEN_W'(w_take);

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_held      = r_held;
        n_code      = r_code;
        n_rem       = r_rem;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_emit      = 1'b0;
        unique case (r_state)
            hcbp_pkg::ST_IDLE: begin
                if (w_accept) begin
                    priority if (i_in_data.kind == hcbp_pkg::KIND_ENCODE && w_in_range) begin
                        n_state = hcbp_pkg::ST_READ;
                    end else if (i_in_data.kind == hcbp_pkg::KIND_FLUSH) begin
                        // An empty accumulator already reads as zero.
                        if (r_held != 3'd0) begin
                            n_state = hcbp_pkg::ST_FLUSH;
                        end
                    end else begin
                        n_state = hcbp_pkg::ST_IDLE;
                    end
                end
            end
            hcbp_pkg::ST_READ: begin
                // Left-align the code so the first bit sits at the top.
                n_code  = SH_W'(w_rd_code) << w_align_sh;
                n_rem   = w_rd_len;
                n_state = (w_rd_len == '0) ? hcbp_pkg::ST_IDLE : hcbp_pkg::ST_STEP;
            end
            hcbp_pkg::ST_STEP: begin
                if (w_out_free) begin
                    n_code = r_code << w_take;
                    n_rem  = w_rem_next;
                    if (w_held_sum[3]) begin
                        w_emit              = 1'b1;
                        n_out_valid         = 1'b1;
                        n_out.out_byte      = w_cat[15:8];
                        // Another byte follows only if a full byte of code remains.
                        n_out.run_last      = (CNT_W'(w_rem_next) < CNT_W'(8));
                        n_out.stream_end    = 1'b0;
                        n_acc               = 8'd0;
                        n_held              = 3'd0;
                    end else begin
                        n_acc  = w_cat[15:8];
                        n_held = w_held_sum[2:0];
                    end
                    if (w_rem_next == '0) begin
                        n_state = hcbp_pkg::ST_IDLE;
                    end
                end
            end
            hcbp_pkg::ST_FLUSH: begin
                if (w_out_free) begin
                    w_emit           = 1'b1;
                    n_out_valid      = 1'b1;
                    n_out.out_byte   = r_acc << (4'd8 - {1'b0, r_held});
                    n_out.run_last   = 1'b1;
                    n_out.stream_end = 1'b1;
                    n_acc            = 8'd0;
                    n_held           = 3'd0;
                    n_state          = hcbp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hcbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hcbp_pkg::ST_IDLE;
            r_acc       <= 8'd0;
            r_held      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_rem  <= n_rem;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A flush step that finds the output register free completes this cycle.
    assign w_flush_xfer = (r_state == hcbp_pkg::ST_FLUSH) && w_out_free;

    // A packing step always has code bits left to move.
    `HCBP_ASSERT_NOW(a_step_has_bits, i_clk, i_rst_n, r_state == hcbp_pkg::ST_STEP, r_rem != '0)
    // A new byte never overwrites one that is still waiting downstream.
    `HCBP_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_emit, w_out_free)
    // After a flush transfer the accumulator is empty.
    `HCBP_ASSERT_NEXT(a_flush_clears, i_clk, i_rst_n, w_flush_xfer, r_held == 3'd0)

endmodule

// ===== verif/huffman_code_bit_packer_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Huffman code bit packer: table loads, encodes and flushes.
module huffman_code_bit_packer_test;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;

    // The fourth item kind has no name in the package; the block must ignore it.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Upper bound on the run length in cycles, with room for heavy stalling.
    localparam int CYCLE_LIMIT = 400000;

    // Cycles to keep watching after the last expected byte. An encode needs a table read,
    // an alignment and up to five packing steps, so this leaves ample margin.
    localparam int SETTLE_CYCLES = 32;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    hcbp_pkg::t_in_item  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    hcbp_pkg::t_out_item o_out_data;

    huffman_code_bit_packer #(
        .MAX_CODE_LEN(MAX_CODE_LEN),
        .SYMBOL_COUNT(SYMBOL_COUNT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Idle rates in percent, set by each test before it starts sending.
    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    // A test asks for a long receiver hold-off by bumping the sequence number; the
    // receiver process then counts the cycles down on its own.
    int hold_request_len = 0;
    int hold_request_seq = 0;
    int hold_seen_seq    = 0;
    int hold_left        = 0;

    int mismatches  = 0;
    int cycle_count = 0;

    // Shadow copy of the code table and the bit packer. Only entries that were loaded
    // are ever encoded, since the table holds garbage until written.
    logic [31:0] code_table   [SYMBOL_COUNT];
    logic [5:0]  length_table [SYMBOL_COUNT];
    bit          entry_loaded [SYMBOL_COUNT];
    int          loaded_symbols [$];
    logic [7:0]  pack_acc   = '0;
    int          pack_count = 0;

    // Bytes still owed by the block, oldest first.
    hcbp_pkg::t_out_item pending_bytes [$];

    // Applies one transfer to the shadow state and queues the bytes it must produce.
    task automatic predict_packed_bytes(input hcbp_pkg::t_in_item it);
        int                  n;
        logic [63:0]         mask;
        logic [7:0]          padded;
        hcbp_pkg::t_out_item made [$];
        unique case (it.kind)
            hcbp_pkg::KIND_LOAD: begin
                // Long codes saturate; bits above the length are dropped.
                n    = (it.code_len > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(it.code_len);
                mask = (64'd1 << n) - 64'd1;
                code_table[it.symbol]   = it.code_bits & mask[31:0];
                length_table[it.symbol] = 6'(n);
                if (!entry_loaded[it.symbol]) begin
                    entry_loaded[it.symbol] = 1'b1;
                    loaded_symbols.push_back(int'(it.symbol));
                end
            end
            hcbp_pkg::KIND_ENCODE: begin
                // Most significant code bit goes first; every full byte leaves at once.
                for (int i = length_table[it.symbol]; i > 0; i--) begin
                    pack_acc = {pack_acc[6:0], code_table[it.symbol][i - 1]};
                    pack_count++;
                    if (pack_count == 8) begin
                        made.push_back('{out_byte: pack_acc, run_last: 1'b0, stream_end: 1'b0});
                        pack_acc   = '0;
                        pack_count = 0;
                    end
                end
                if (made.size() > 0) begin
                    made[made.size() - 1].run_last = 1'b1;
                end
            end
            hcbp_pkg::KIND_FLUSH: begin
                // A flush with nothing held produces no byte.
                if (pack_count > 0) begin
                    padded = pack_acc << (8 - pack_count);
                    made.push_back('{out_byte: padded, run_last: 1'b1, stream_end: 1'b1});
                end
                pack_acc   = '0;
                pack_count = 0;
            end
            default: begin
            end
        endcase
        foreach (made[k]) begin
            pending_bytes.push_back(made[k]);
        end
    endtask

    // Offers one item after a random gap and returns at the edge where it transfers.
    // Valid is left high, so the caller either sends again or drains.
    task automatic send_item(input hcbp_pkg::t_in_item it);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_packed_bytes(it);
    endtask

    // Stops offering items and waits until every owed byte has arrived.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic hcbp_pkg::t_in_item make_item(input logic [1:0] kind,
                                                     input logic [7:0] symbol,
                                                     input logic [31:0] bits,
                                                     input logic [5:0] len);
        hcbp_pkg::t_in_item it;
        it.kind      = kind;
        it.symbol    = symbol;
        it.code_bits = bits;
        it.code_len  = len;
        return it;
    endfunction

    // Mostly encodes of loaded symbols, with reloads, flushes and a little noise mixed in.
    // Code lengths are mostly legal, sometimes zero and sometimes past the maximum.
    task automatic random_items(input int count);
        int                 pick;
        hcbp_pkg::t_in_item it;
        repeat (count) begin
            pick = $urandom_range(99);
            it   = make_item(hcbp_pkg::KIND_ENCODE, 8'($urandom), $urandom, 6'($urandom));
            if (pick < 18 || loaded_symbols.size() == 0) begin
                it.kind = hcbp_pkg::KIND_LOAD;
                pick    = $urandom_range(99);
                if (pick < 8) begin
                    it.code_len = 6'd0;
                end else if (pick < 16) begin
                    it.code_len = 6'($urandom_range(63, MAX_CODE_LEN + 1));
                end else begin
                    it.code_len = 6'($urandom_range(MAX_CODE_LEN, 1));
                end
            end else if (pick < 85) begin
                it.symbol = 8'(loaded_symbols[$urandom_range(loaded_symbols.size() - 1)]);
            end else if (pick < 95) begin
                it.kind = hcbp_pkg::KIND_FLUSH;
            end else begin
                it.kind = KIND_UNUSED;
            end
            send_item(it);
        end
    endtask

    task automatic check_byte(input hcbp_pkg::t_out_item got);
        hcbp_pkg::t_out_item want;
        if (pending_bytes.size() == 0) begin
            $error("unexpected output byte %02h", got.out_byte);
            mismatches++;
            return;
        end
        want = pending_bytes.pop_front();
        if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
            mismatches++;
        end
        if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
            mismatches++;
        end
        if (got.stream_end !== want.stream_end) begin
            $error("stream_end: expected %0b, got %0b", want.stream_end, got.stream_end);
            mismatches++;
        end
    endtask

    // Receiver: checks each transfer against the oldest owed byte, then picks the
    // stall for the next cycle, honoring any long hold-off that a test asked for.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_byte(o_out_data);
        end
        if (hold_request_seq != hold_seen_seq) begin
            hold_seen_seq = hold_request_seq;
            hold_left     = hold_request_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Corner cases: zero length, full 32-bit codes, saturated length, stray high bits,
    // an exact byte fill, empty flushes, the unused kind and overwriting an entry.
    task automatic test_directed_cases();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        send_item(make_item(hcbp_pkg::KIND_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd0));
        send_item(make_item(hcbp_pkg::KIND_LOAD,   8'd255, 32'hFFFF_FFFF, 6'd32));
        send_item(make_item(hcbp_pkg::KIND_LOAD,   8'd1,   32'hA5A5_A5A5, 6'd63));
        send_item(make_item(hcbp_pkg::KIND_LOAD,   8'd2,   32'hFFFF_FFFF, 6'd1));
        send_item(make_item(hcbp_pkg::KIND_LOAD,   8'd3,   32'h0000_0055, 6'd7));
        send_item(make_item(hcbp_pkg::KIND_LOAD,   8'd4,   32'h0000_0000, 6'd32));
        send_item(make_item(KIND_UNUSED,           8'hFF,  32'hFFFF_FFFF, 6'h3F));
        send_item(make_item(hcbp_pkg::KIND_FLUSH,  8'd0,   32'h0,         6'd0));
        send_item(make_item(hcbp_pkg::KIND_ENCODE, 8'd0,   32'h0,         6'd0));
        send_item(make_item(hcbp_pkg::KIND_ENCODE, 8'd2,   32'h0,         6'd0));
        send_item(make_item(hcbp_pkg::KIND_FLUSH,  8'hFF,  32'hFFFF_FFFF, 6'h3F));
        send_item(make_item(hcbp_pkg::KIND_ENCODE, 8'd255, 32'h0,         6'd0));
        send_item(make_item(hcbp_pkg::KIND_ENCODE, 8'd1,   32'h0,         6'd0));
        send_item(make_item(hcbp_pkg::KIND_ENCODE, 8'd3,   32'h0,         6'd0));
        send_item(make_item(hcbp_pkg::KIND_ENCODE, 8'd2,   32'h0,         6'd0));
        send_item(make_item(hcbp_pkg::KIND_FLUSH,  8'd0,   32'h0,         6'd0));
        send_item(make_item(hcbp_pkg::KIND_ENCODE, 8'd3,   32'h0,         6'd0));
        send_item(make_item(hcbp_pkg::KIND_ENCODE, 8'd255, 32'h0,         6'd0));
        send_item(make_item(hcbp_pkg::KIND_ENCODE, 8'd4,   32'h0,         6'd0));
        send_item(make_item(hcbp_pkg::KIND_FLUSH,  8'd0,   32'h0,         6'd0));
        send_item(make_item(hcbp_pkg::KIND_LOAD,   8'd2,   32'hFFFF_FFFE, 6'd2));
        send_item(make_item(hcbp_pkg::KIND_ENCODE, 8'd2,   32'h0,         6'd0));
        send_item(make_item(hcbp_pkg::KIND_FLUSH,  8'd0,   32'h0,         6'd0));
        drain_results();
    endtask

    task automatic test_random_no_idle();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        random_items(100);
        drain_results();
    endtask

    task automatic test_random_sender_gaps();
        in_idle_pct   = 79;
        out_stall_pct = 0;
        random_items(100);
        drain_results();
    endtask

    task automatic test_random_receiver_stalls();
        in_idle_pct   = 0;
        out_stall_pct = 79;
        random_items(100);
        drain_results();
    endtask

    task automatic test_random_both_idle();
        in_idle_pct   = 25;
        out_stall_pct = 25;
        random_items(100);
        drain_results();
    endtask

    // The receiver holds off long enough for the block to fill and stall its input
    // while items keep coming. Then the sender pauses until everything is out, and
    // a short burst follows on the emptied pipeline.
    task automatic test_output_backpressure();
        in_idle_pct      = 0;
        out_stall_pct    = 0;
        hold_request_len = 300;
        hold_request_seq++;
        random_items(40);
        drain_results();
        random_items(10);
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_no_idle();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_idle();
        test_output_backpressure();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
